// File: hdl/audio_dynamic_rate_control_macros.svh
// Assertion macros used by the rate control RTL
`ifndef AUDIO_DYNAMIC_RATE_CONTROL_MACROS_SVH
`define AUDIO_DYNAMIC_RATE_CONTROL_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ADRC_ASSERT_IMPL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define ADRC_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`endif

// File: hdl/adrc_pkg.sv
// Shared widths, constants and types for the audio dynamic rate control block
package adrc_pkg;

   parameter int ADRC_NUM_SOURCES = 8;
   parameter int ADRC_MAX_QUEUE   = 8;

   // field widths
   parameter int ADRC_SRC_W    = 3;
   parameter int ADRC_TICK_W   = 32;
   parameter int ADRC_FRAMES_W = 16;
   parameter int ADRC_RATE_W   = 18;
   parameter int ADRC_DEPTH_W  = 4;
   parameter int ADRC_PITCH_W  = 17;
   parameter int ADRC_STATE_W  = 18;
   parameter int ADRC_CSR_IDX_W  = 1;
   parameter int ADRC_CSR_DATA_W = 8;
   parameter int ADRC_EXCL_W     = 8;

   // Q2.16 ratios and filter coefficients
   parameter int ADRC_FRAC_W     = 16;
   parameter int ADRC_Q_ONE      = 65536;
   parameter int ADRC_Q_LOW      = 16384;
   parameter int ADRC_Q_HIGH     = 81920;
   parameter int ADRC_ROUND_HALF = 32768;
   parameter int ADRC_C_SPD_NEW  = 3277;
   parameter int ADRC_C_SPD_OLD  = 62259;
   parameter int ADRC_C_QSTEP    = 2621;
   parameter int ADRC_C_PIT_NEW  = 6554;
   parameter int ADRC_C_PIT_OLD  = 58982;
   parameter int ADRC_TARGET_DEPTH = 4;
   parameter int ADRC_Q_OFFSET   = ADRC_C_QSTEP * ADRC_TARGET_DEPTH;
   parameter int ADRC_GAP_MIN    = 5;
   parameter int ADRC_GAP_MAX    = 500;
   parameter int ADRC_MS_PER_S   = 1000;
   parameter int ADRC_EXCL_RESET = 48;

   // datapath widths
   parameter int ADRC_FK_W   = 26;                        // frames * 1000
   parameter int ADRC_NUM_W  = ADRC_FK_W + ADRC_FRAC_W;   // dividend
   parameter int ADRC_GAP_W  = 9;                         // gap up to 500 ms
   parameter int ADRC_DEN_W  = ADRC_RATE_W + ADRC_GAP_W;  // divisor
   parameter int ADRC_QUO_W  = 18;
   parameter int ADRC_COEF_W = 16;
   parameter int ADRC_ACC_W  = 34;
   parameter int ADRC_QCMP_W = 6;

   typedef enum logic [ADRC_CSR_IDX_W-1:0] {
      CSR_ENABLE   = 1'b0,
      CSR_EXCLUDED = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic done;
      logic overflow;
   } div_stat_type;

endpackage

// File: hdl/adrc_req_if.sv
// Request channel: one audio buffer report
interface adrc_req_if import adrc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ADRC_SRC_W-1:0]    source_id;
   logic [ADRC_TICK_W-1:0]   tick_ms;
   logic [ADRC_FRAMES_W-1:0] frame_count;
   logic [ADRC_RATE_W-1:0]   sample_rate;
   logic [ADRC_DEPTH_W-1:0]  queue_depth;
   logic                     bypass;

   modport source (output valid, source_id, tick_ms, frame_count, sample_rate,
                   queue_depth, bypass, input ready);
   modport sink   (input valid, source_id, tick_ms, frame_count, sample_rate,
                   queue_depth, bypass, output ready);
endinterface

// File: hdl/adrc_rsp_if.sv
// Response channel: pitch result for one request
interface adrc_rsp_if import adrc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ADRC_PITCH_W-1:0] pitch_ratio;
   logic                    pitch_written;
   logic                    stall_reset;

   modport source (output valid, pitch_ratio, pitch_written, stall_reset, input ready);
   modport sink   (input valid, pitch_ratio, pitch_written, stall_reset, output ready);
endinterface

// File: hdl/adrc_csr_if.sv
// Register write channel
interface adrc_csr_if import adrc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [ADRC_CSR_IDX_W-1:0]  index;
   logic [ADRC_CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/adrc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, with overflow flag
module adrc_div import adrc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ADRC_NUM_W-1:0] num,
   input  logic [ADRC_DEN_W-1:0] den,
   output logic [ADRC_QUO_W-1:0] quo,
   output div_stat_type          stat
);

   localparam int CNT_W = $clog2(ADRC_NUM_W + 1);

   logic [ADRC_NUM_W-1:0] num_sh_ff;
   logic [ADRC_DEN_W-1:0] den_ff;
   logic [ADRC_DEN_W-1:0] rem_ff;
   logic [ADRC_DEN_W-1:0] rem_in;
   logic [ADRC_QUO_W-1:0] quo_ff;
   logic                  ovf_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [ADRC_DEN_W:0]   trial;
   logic [ADRC_DEN_W:0]   diff;
   logic                  take;

   always_comb begin
      trial  = {rem_ff, num_sh_ff[ADRC_NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      take   = (trial >= {1'b0, den_ff});
      rem_in = take ? diff[ADRC_DEN_W-1:0] : trial[ADRC_DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ADRC_NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_sh_ff <= num;
         den_ff    <= den;
         rem_ff    <= '0;
         quo_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else if (busy_ff) begin
         num_sh_ff <= {num_sh_ff[ADRC_NUM_W-2:0], 1'b0};
         rem_ff    <= rem_in;
         quo_ff    <= {quo_ff[ADRC_QUO_W-2:0], take};
         ovf_ff    <= ovf_ff | quo_ff[ADRC_QUO_W-1];
      end
   end

   always_comb begin
      quo           = quo_ff;
      stat.done     = done_ff;
      stat.overflow = ovf_ff;
   end

endmodule

// File: hdl/audio_dynamic_rate_control.sv
// Top level: per-source speed and pitch tracking for audio buffer reports
//
//   channel  dir  accepted when         carries
//   req_ch   in   valid && ready        source, tick, frames, rate, depth, bypass
//   rsp_ch   out  valid && ready        pitch ratio, written flag, stall flag
//   csr_ch   in   valid && ready        register index, write data
//
// A request whose gap is in range runs the bit-serial divide of buffer duration by
// gap and then the filter steps before it responds; other requests skip both.
// One request is in work at a time.
// A response waiting on rsp_ch does not block the next request; a finished
// request waits only if the previous response is still unread.
// Synchronous reset clears all per-source state to its initial values.
`include "audio_dynamic_rate_control_macros.svh"

module audio_dynamic_rate_control import adrc_pkg::*; #(
   parameter int NUM_SOURCES = ADRC_NUM_SOURCES
) (
   input  logic       clock,
   input  logic       reset,
   adrc_req_if.sink   req_ch,
   adrc_rsp_if.source rsp_ch,
   adrc_csr_if.sink   csr_ch
);

   localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_DECIDE, ST_DIV_START, ST_DIV_WAIT,
      ST_SPD_A, ST_SPD_B, ST_TGT, ST_PIT_A, ST_PIT_B, ST_FINISH
   } state_type;

   state_type state_ff;

   // registers
   logic                     enable_ff;
   logic [ADRC_EXCL_W-1:0]   excluded_ff;
   logic [ADRC_TICK_W-1:0]   last_tick_ff [NUM_SOURCES];
   logic [ADRC_STATE_W-1:0]  speed_ff     [NUM_SOURCES];
   logic [ADRC_STATE_W-1:0]  pitch_ff     [NUM_SOURCES];

   // request fields
   logic [ADRC_SRC_W-1:0]    src_ff;
   logic [ADRC_TICK_W-1:0]   now_ff;
   logic [ADRC_FRAMES_W-1:0] frames_ff;
   logic [ADRC_RATE_W-1:0]   rate_ff;
   logic [ADRC_DEPTH_W-1:0]  depth_ff;
   logic [ADRC_DEPTH_W-1:0]  depth_in;
   logic                     bypass_ff;

   // working values
   logic [ADRC_TICK_W-1:0]   lt_ff;
   logic [ADRC_TICK_W-1:0]   delta_ff;
   logic [ADRC_STATE_W-1:0]  fs_ff;
   logic [ADRC_STATE_W-1:0]  ps_ff;
   logic                     range_ok_ff;
   logic                     active_ff;
   logic [ADRC_NUM_W-1:0]    num_ff;
   logic [ADRC_DEN_W-1:0]    den_ff;
   logic [ADRC_ACC_W-1:0]    acc_ff;
   logic [ADRC_STATE_W-1:0]  fs_new_ff;
   logic [ADRC_STATE_W-1:0]  ps_new_ff;
   logic [ADRC_STATE_W-1:0]  tgt_ff;
   logic [ADRC_STATE_W-1:0]  tgt_in;
   logic [ADRC_STATE_W-1:0]  pitch_res_ff;
   logic                     wr_tick_ff;
   logic                     wr_filt_ff;
   logic                     written_ff;
   logic                     stall_ff;

   // response register
   logic                     rsp_valid_ff;
   logic [ADRC_PITCH_W-1:0]  pitch_out_ff;
   logic                     written_out_ff;
   logic                     stall_out_ff;

   logic [IDX_W-1:0]         idx;
   logic                     accept;
   logic                     commit;
   logic                     dec_idle;
   logic                     dec_short;
   logic                     dec_stall;
   logic [ADRC_QUO_W-1:0]    div_quo;
   div_stat_type             div_stat;
   logic [ADRC_STATE_W-1:0]  inst;
   logic [ADRC_COEF_W-1:0]   mul_a;
   logic [ADRC_STATE_W-1:0]  mul_b;
   logic [ADRC_ACC_W-1:0]    prod;
   logic [ADRC_ACC_W-1:0]    sum;
   logic [ADRC_FK_W-1:0]     frames_k;
   logic [ADRC_DEN_W-1:0]    den_in;
   logic [ADRC_STATE_W-1:0]  qadj;
   logic signed [ADRC_STATE_W+1:0] tgt_s;

   assign idx          = IDX_W'(src_ff);
   assign accept       = req_ch.valid && req_ch.ready;
   assign commit       = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pitch_ratio   = pitch_out_ff;
   assign rsp_ch.pitch_written = written_out_ff;
   assign rsp_ch.stall_reset   = stall_out_ff;

   always_comb begin
      if ({2'b00, req_ch.queue_depth} > ADRC_QCMP_W'(ADRC_MAX_QUEUE)) begin
         depth_in = ADRC_DEPTH_W'(ADRC_MAX_QUEUE);
      end else begin
         depth_in = req_ch.queue_depth;
      end
   end

   always_comb begin
      dec_idle  = !range_ok_ff || !active_ff;
      dec_short = (lt_ff == '0) || (delta_ff < ADRC_TICK_W'(ADRC_GAP_MIN));
      dec_stall = (delta_ff > ADRC_TICK_W'(ADRC_GAP_MAX));
   end

   // instant speed from the divider, clamped
   always_comb begin
      if (div_stat.overflow || div_quo > ADRC_QUO_W'(ADRC_Q_HIGH)) begin
         inst = ADRC_STATE_W'(ADRC_Q_HIGH);
      end else if (div_quo < ADRC_QUO_W'(ADRC_Q_LOW)) begin
         inst = ADRC_STATE_W'(ADRC_Q_LOW);
      end else begin
         inst = div_quo;
      end
   end

   // shared filter multiplier
   always_comb begin
      case (state_ff)
         ST_SPD_A: begin
            mul_a = ADRC_COEF_W'(ADRC_C_SPD_NEW);
            mul_b = inst;
         end
         ST_SPD_B: begin
            mul_a = ADRC_COEF_W'(ADRC_C_SPD_OLD);
            mul_b = fs_ff;
         end
         ST_PIT_A: begin
            mul_a = ADRC_COEF_W'(ADRC_C_PIT_NEW);
            mul_b = tgt_ff;
         end
         ST_PIT_B: begin
            mul_a = ADRC_COEF_W'(ADRC_C_PIT_OLD);
            mul_b = ps_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = ADRC_ACC_W'(mul_a) * ADRC_ACC_W'(mul_b);
      sum  = acc_ff + prod;
   end

   // pitch target: speed plus queue correction, clamped
   always_comb begin
      qadj  = ADRC_STATE_W'(depth_ff) * ADRC_STATE_W'(ADRC_C_QSTEP);
      tgt_s = $signed({2'b00, fs_new_ff}) + $signed({2'b00, qadj})
              - $signed((ADRC_STATE_W+2)'(ADRC_Q_OFFSET));
      if (tgt_s < $signed((ADRC_STATE_W+2)'(ADRC_Q_LOW))) begin
         tgt_in = ADRC_STATE_W'(ADRC_Q_LOW);
      end else if (tgt_s > $signed((ADRC_STATE_W+2)'(ADRC_Q_HIGH))) begin
         tgt_in = ADRC_STATE_W'(ADRC_Q_HIGH);
      end else begin
         tgt_in = tgt_s[ADRC_STATE_W-1:0];
      end
   end

   always_comb begin
      frames_k = ADRC_FK_W'(frames_ff) * ADRC_FK_W'(ADRC_MS_PER_S);
      den_in   = ADRC_DEN_W'(rate_ff) * ADRC_DEN_W'(delta_ff[ADRC_GAP_W-1:0]);
   end

   adrc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DIV_START),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         excluded_ff <= ADRC_EXCL_W'(ADRC_EXCL_RESET);
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_reg_type'(csr_ch.index))
            CSR_ENABLE:   enable_ff   <= csr_ch.data[0];
            CSR_EXCLUDED: excluded_ff <= csr_ch.data;
         endcase
      end
   end

   // per-source state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            last_tick_ff[i] <= '0;
            speed_ff[i]     <= ADRC_STATE_W'(ADRC_Q_ONE);
            pitch_ff[i]     <= ADRC_STATE_W'(ADRC_Q_ONE);
         end
      end else if (commit) begin
         if (wr_tick_ff) begin
            last_tick_ff[idx] <= now_ff;
         end
         if (wr_filt_ff) begin
            speed_ff[idx] <= fs_new_ff;
            pitch_ff[idx] <= ps_new_ff;
         end
      end
   end

   // sequencer and registered control outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wr_tick_ff   <= 1'b0;
         wr_filt_ff   <= 1'b0;
         written_ff   <= 1'b0;
         stall_ff     <= 1'b0;
      end else begin
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               wr_tick_ff <= 1'b0;
               wr_filt_ff <= 1'b0;
               written_ff <= 1'b0;
               stall_ff   <= 1'b0;
               state_ff   <= ST_FINISH;
               if (!dec_idle) begin
                  wr_tick_ff <= 1'b1;
                  if (!dec_short) begin
                     wr_filt_ff <= 1'b1;
                     written_ff <= 1'b1;
                     if (dec_stall) begin
                        stall_ff <= 1'b1;
                     end else begin
                        state_ff <= ST_DIV_START;
                     end
                  end
               end
            end
            ST_DIV_START: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_stat.done) begin
                  state_ff <= ST_SPD_A;
               end
            end
            ST_SPD_A: state_ff <= ST_SPD_B;
            ST_SPD_B: state_ff <= ST_TGT;
            ST_TGT:   state_ff <= ST_PIT_A;
            ST_PIT_A: state_ff <= ST_PIT_B;
            ST_PIT_B: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff    <= req_ch.source_id;
         now_ff    <= req_ch.tick_ms;
         frames_ff <= req_ch.frame_count;
         rate_ff   <= req_ch.sample_rate;
         depth_ff  <= depth_in;
         bypass_ff <= req_ch.bypass;
      end
      case (state_ff)
         ST_FETCH: begin
            lt_ff       <= last_tick_ff[idx];
            delta_ff    <= now_ff - last_tick_ff[idx];
            fs_ff       <= speed_ff[idx];
            ps_ff       <= pitch_ff[idx];
            range_ok_ff <= (int'(src_ff) < NUM_SOURCES);
            active_ff   <= enable_ff && !bypass_ff && !excluded_ff[src_ff]
                           && (rate_ff != '0);
         end
         ST_DECIDE: begin
            num_ff       <= {frames_k, ADRC_FRAC_W'(0)};
            den_ff       <= den_in;
            pitch_res_ff <= range_ok_ff ? ps_ff : '0;
            fs_new_ff    <= ADRC_STATE_W'(ADRC_Q_ONE);
            ps_new_ff    <= ADRC_STATE_W'(ADRC_Q_ONE);
            if (!dec_idle && !dec_short && dec_stall) begin
               pitch_res_ff <= ADRC_STATE_W'(ADRC_Q_ONE);
            end
         end
         ST_SPD_A: acc_ff    <= ADRC_ACC_W'(ADRC_ROUND_HALF) + prod;
         ST_SPD_B: fs_new_ff <= sum[ADRC_ACC_W-1:ADRC_FRAC_W];
         ST_TGT:   tgt_ff    <= tgt_in;
         ST_PIT_A: acc_ff    <= ADRC_ACC_W'(ADRC_ROUND_HALF) + prod;
         ST_PIT_B: begin
            ps_new_ff    <= sum[ADRC_ACC_W-1:ADRC_FRAC_W];
            pitch_res_ff <= sum[ADRC_ACC_W-1:ADRC_FRAC_W];
         end
         default: ;
      endcase
      if (commit) begin
         pitch_out_ff   <= pitch_res_ff[ADRC_PITCH_W-1:0];
         written_out_ff <= written_ff;
         stall_out_ff   <= stall_ff;
      end
   end

   `ADRC_ASSERT_IMPL(a_stall_has_write, rsp_valid_ff |-> (!stall_out_ff || written_out_ff), "stall response without pitch write")
   `ADRC_ASSERT_IMPL(a_pitch_range, rsp_valid_ff |-> (pitch_out_ff == '0 || (pitch_out_ff >= ADRC_PITCH_W'(ADRC_Q_LOW) && pitch_out_ff <= ADRC_PITCH_W'(ADRC_Q_HIGH))), "pitch ratio out of range")
   `ADRC_ASSERT_IMPL(a_div_done_wait, div_stat.done |-> (state_ff == ST_DIV_WAIT), "divider finished outside wait state")
   `ADRC_ASSERT_NEXT(a_accept_fetch, req_ch.valid && req_ch.ready, state_ff == ST_FETCH, "accepted request not fetched")

endmodule

// File: sim/audio_dynamic_rate_control_test.sv
// Testbench for audio_dynamic_rate_control: directed table, then random buffer streams.
`timescale 1ns / 100ps

module audio_dynamic_rate_control_test;
   import adrc_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int ITEMS          = 600;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int MISMATCH_SHOWN = 10;
   localparam int N_DIRECTED     = 24;

   typedef struct packed {
      logic [ADRC_SRC_W-1:0]    source_id;
      logic [ADRC_TICK_W-1:0]   tick_ms;
      logic [ADRC_FRAMES_W-1:0] frame_count;
      logic [ADRC_RATE_W-1:0]   sample_rate;
      logic [ADRC_DEPTH_W-1:0]  queue_depth;
      logic                     bypass;
   } audio_buf_type;

   typedef struct packed {
      logic [ADRC_PITCH_W-1:0] pitch_ratio;
      logic                    pitch_written;
      logic                    stall_reset;
   } pitch_res_type;

   typedef enum {ROW_BUF, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      csr_reg_type                reg_idx;
      logic [ADRC_CSR_DATA_W-1:0] reg_data;
      audio_buf_type              req;
      bit                         typed;
      pitch_res_type              want;
   } dir_row_type;

   localparam audio_buf_type NO_BUF   = '0;
   localparam pitch_res_type AT_UNITY = '{17'(ADRC_Q_ONE), 1'b0, 1'b0};
   localparam pitch_res_type STALLED  = '{17'(ADRC_Q_ONE), 1'b1, 1'b1};

   // typed rows: ignored requests, first buffer of a stream, stalls
   dir_row_type directed [N_DIRECTED] = '{
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd0, 32'd100, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b1, AT_UNITY},
      '{ROW_WRITE, CSR_ENABLE,   8'h01, NO_BUF, 1'b0, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd0, 32'd0, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b1, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd0, 32'd20, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b1, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd0, 32'd40, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b0, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd0, 32'd43, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b0, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd0, 32'd48, 16'hFFFF, 18'd1, 4'd15, 1'b0}, 1'b0, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd0, 32'd548, 16'd0, 18'h3FFFF, 4'd0, 1'b0}, 1'b0, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd0, 32'd1049, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b1, STALLED},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd0, 32'd1100, 16'd960, 18'd48000, 4'd4, 1'b1}, 1'b1, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd1, 32'd100, 16'd960, 18'd0, 4'd4, 1'b0}, 1'b1, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd4, 32'd100, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b1, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd7, 32'hFFFF_FFF0, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b1, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd7, 32'h0000_0004, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b0, AT_UNITY},
      '{ROW_WRITE, CSR_EXCLUDED, 8'h00, NO_BUF, 1'b0, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd4, 32'd200, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b1, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd4, 32'd220, 16'hFFFF, 18'h3FFFF, 4'd8, 1'b0}, 1'b0, AT_UNITY},
      '{ROW_WRITE, CSR_EXCLUDED, 8'hFF, NO_BUF, 1'b0, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd2, 32'd300, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b1, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd0, 32'd1060, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b1, AT_UNITY},
      '{ROW_WRITE, CSR_EXCLUDED, 8'd48, NO_BUF, 1'b0, AT_UNITY},
      '{ROW_WRITE, CSR_ENABLE,   8'hFE, NO_BUF, 1'b0, AT_UNITY},
      '{ROW_BUF,   CSR_ENABLE,   8'h00,
        '{3'd3, 32'd50, 16'd960, 18'd48000, 4'd4, 1'b0}, 1'b1, AT_UNITY},
      '{ROW_WRITE, CSR_ENABLE,   8'h01, NO_BUF, 1'b0, AT_UNITY}
   };

   logic clock = 1'b0;
   logic reset;

   adrc_req_if req_bus ();
   adrc_rsp_if rsp_bus ();
   adrc_csr_if csr_bus ();

   audio_dynamic_rate_control u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // per-source tracking state and register copies
   logic [ADRC_TICK_W-1:0]  last_seen_ms [ADRC_NUM_SOURCES];
   logic [ADRC_STATE_W-1:0] speed_q      [ADRC_NUM_SOURCES];
   logic [ADRC_STATE_W-1:0] pitch_q      [ADRC_NUM_SOURCES];
   logic                    ctl_enable;
   logic [ADRC_EXCL_W-1:0]  ctl_excluded;

   // stimulus streams, one per source
   logic [ADRC_TICK_W-1:0] stream_clock [ADRC_NUM_SOURCES];
   logic [ADRC_RATE_W-1:0] stream_rate  [ADRC_NUM_SOURCES];

   pitch_res_type pending_pitch [$];
   pitch_res_type oldest;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            stall_left = 0;
   bit            gaps_on = 1'b1;
   bit            stalls_on = 1'b1;

   always #HALF_PERIOD clock = ~clock;

   function automatic longint clamp_q(longint v);
      if (v < ADRC_Q_LOW) return ADRC_Q_LOW;
      if (v > ADRC_Q_HIGH) return ADRC_Q_HIGH;
      return v;
   endfunction

   // one low-pass step, rounded half up
   function automatic logic [ADRC_STATE_W-1:0] blend(longint a, longint x,
                                                     longint b, longint y);
      return ADRC_STATE_W'((a * x + b * y + ADRC_ROUND_HALF) >>> ADRC_FRAC_W);
   endfunction

   function automatic pitch_res_type track_buffer(input audio_buf_type b);
      pitch_res_type r;
      int s;
      logic [ADRC_TICK_W-1:0] gap;
      longint depth, quo, tgt;
      s = int'(b.source_id);
      r = '0;
      if (s >= ADRC_NUM_SOURCES) return r;
      depth = (b.queue_depth > ADRC_MAX_QUEUE) ? ADRC_MAX_QUEUE : longint'(b.queue_depth);
      if (ctl_enable && !b.bypass && !ctl_excluded[s] && b.sample_rate != 0) begin
         if (last_seen_ms[s] != 0) begin
            gap = b.tick_ms - last_seen_ms[s];
            if (gap >= ADRC_GAP_MIN && gap <= ADRC_GAP_MAX) begin
               quo = longint'(64'(b.frame_count) * ADRC_MS_PER_S * ADRC_Q_ONE
                              / (64'(b.sample_rate) * 64'(gap)));
               speed_q[s] = blend(ADRC_C_SPD_NEW, clamp_q(quo), ADRC_C_SPD_OLD,
                                  longint'(speed_q[s]));
               tgt = longint'(speed_q[s]) + ADRC_C_QSTEP * (depth - ADRC_TARGET_DEPTH);
               pitch_q[s] = blend(ADRC_C_PIT_NEW, clamp_q(tgt), ADRC_C_PIT_OLD,
                                  longint'(pitch_q[s]));
               r.pitch_written = 1'b1;
            end else if (gap > ADRC_GAP_MAX) begin
               speed_q[s] = ADRC_Q_ONE;
               pitch_q[s] = ADRC_Q_ONE;
               r.pitch_written = 1'b1;
               r.stall_reset = 1'b1;
            end
         end
         last_seen_ms[s] = b.tick_ms;
      end
      r.pitch_ratio = pitch_q[s][ADRC_PITCH_W-1:0];
      return r;
   endfunction

   function automatic int pick_gap(bit on);
      int r;
      if (!on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   function automatic logic [ADRC_RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 7))
         0: return 18'd8000;
         1: return 18'd11025;
         2: return 18'd22050;
         3: return 18'd44100;
         4: return 18'd48000;
         5: return 18'd96000;
         6: return 18'd192000;
         default: return ADRC_RATE_W'($urandom_range(1, 2**ADRC_RATE_W - 1));
      endcase
   endfunction

   // mostly plausible buffer streams, some stalls, short gaps and noise
   function automatic audio_buf_type next_buffer();
      audio_buf_type b;
      int s, kind;
      longint step_ms, frames;
      s = $urandom_range(0, ADRC_NUM_SOURCES - 1);
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) stream_rate[s] = pick_rate();
      b.source_id = ADRC_SRC_W'(s);
      b.sample_rate = stream_rate[s];
      b.bypass = 1'b0;
      if ($urandom_range(0, 9) == 0)
         b.queue_depth = ADRC_DEPTH_W'($urandom_range(ADRC_MAX_QUEUE + 1, 15));
      else
         b.queue_depth = ADRC_DEPTH_W'($urandom_range(0, ADRC_MAX_QUEUE));
      if (kind < 66) begin
         step_ms = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 500)
                                               : $urandom_range(15, 30);
      end else if (kind < 76) begin
         step_ms = $urandom_range(501, 3000);
      end else if (kind < 84) begin
         step_ms = $urandom_range(0, 4);
      end else if (kind < 90) begin
         case ($urandom_range(0, 3))
            0: step_ms = 4;
            1: step_ms = 5;
            2: step_ms = 500;
            default: step_ms = 501;
         endcase
      end else begin
         step_ms = $urandom;
      end
      frames = longint'(b.sample_rate) * step_ms * $urandom_range(70, 130) / 100000;
      b.frame_count = (frames > 65535) ? 16'hFFFF : 16'(frames);
      if (kind >= 90) begin
         b.frame_count = 16'($urandom);
         if ($urandom_range(0, 2) == 0)
            b.sample_rate = ($urandom_range(0, 1) == 1) ? '0 : ADRC_RATE_W'($urandom);
         b.bypass = ($urandom_range(0, 2) == 0);
      end
      b.tick_ms = stream_clock[s] + ADRC_TICK_W'(step_ms);
      stream_clock[s] = b.tick_ms;
      return b;
   endfunction

   task automatic send_buffer(input audio_buf_type b, input bit typed, input pitch_res_type want);
      int gap;
      pitch_res_type predicted;
      gap = pick_gap(gaps_on);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.source_id   <= b.source_id;
      req_bus.tick_ms     <= b.tick_ms;
      req_bus.frame_count <= b.frame_count;
      req_bus.sample_rate <= b.sample_rate;
      req_bus.queue_depth <= b.queue_depth;
      req_bus.bypass      <= b.bypass;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = track_buffer(b);
      pending_pitch.push_back(typed ? want : predicted);
   endtask

   // hold off requests until every response is back
   task automatic drain_pending();
      req_bus.valid <= 1'b0;
      while (pending_pitch.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [ADRC_CSR_DATA_W-1:0] value);
      drain_pending();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_ENABLE:   ctl_enable = value[0];
         CSR_EXCLUDED: ctl_excluded = value;
      endcase
   endtask

   task automatic note_mismatch(input string what, input pitch_res_type want);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN)
         $display("%0t %s: expected %0d %0b %0b, actual %0d %0b %0b",
                  $time, what, want.pitch_ratio, want.pitch_written, want.stall_reset,
                  rsp_bus.pitch_ratio, rsp_bus.pitch_written, rsp_bus.stall_reset);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = pick_gap(stalls_on);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_pitch.size() == 0) begin
            note_mismatch("response with no request pending", '0);
         end else begin
            oldest = pending_pitch.pop_front();
            if (rsp_bus.pitch_ratio !== oldest.pitch_ratio ||
                rsp_bus.pitch_written !== oldest.pitch_written ||
                rsp_bus.stall_reset !== oldest.stall_reset)
               note_mismatch("pitch result", oldest);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_pitch.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int         sent_total;
      int         phase;
      int         n;
      logic       en;
      logic [7:0] excl;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.source_id   <= '0;
      req_bus.tick_ms     <= '0;
      req_bus.frame_count <= '0;
      req_bus.sample_rate <= '0;
      req_bus.queue_depth <= '0;
      req_bus.bypass      <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= CSR_ENABLE;
      csr_bus.data        <= '0;
      ctl_enable = 1'b0;
      ctl_excluded = ADRC_EXCL_RESET;
      for (int s = 0; s < ADRC_NUM_SOURCES; s++) begin
         last_seen_ms[s] = '0;
         speed_q[s] = ADRC_Q_ONE;
         pitch_q[s] = ADRC_Q_ONE;
         stream_clock[s] = $urandom;
         stream_rate[s] = pick_rate();
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_WRITE)
            write_csr(directed[i].reg_idx, directed[i].reg_data);
         else
            send_buffer(directed[i].req, directed[i].typed, directed[i].want);
      end

      // random phases; each starts idle with a fresh register setting
      sent_total = 0;
      phase = 0;
      while (sent_total < ITEMS) begin
         case (phase)
            0: begin en = 1'b1; excl = 8'h00; end
            1: begin en = 1'b1; excl = 8'hFF; end
            2: begin en = 1'b0; excl = 8'h00; end
            default: begin
               en = ($urandom_range(0, 7) != 0);
               excl = ($urandom_range(0, 1) == 1) ? 8'(1 << $urandom_range(0, 7))
                                                  : 8'($urandom & $urandom & $urandom);
            end
         endcase
         write_csr(CSR_ENABLE, {7'($urandom), en});
         write_csr(CSR_EXCLUDED, excl);
         gaps_on = (phase % 4 != 1);
         stalls_on = (phase % 3 != 2);
         n = (phase < 3) ? 15 : $urandom_range(20, 60);
         repeat (n) begin
            send_buffer(next_buffer(), 1'b0, AT_UNITY);
            sent_total++;
         end
         phase++;
      end

      drain_pending();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_pitch.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
